>>> rtl/core/capture_interp_decimate_resampler_top_macros.svh
// ---------------------------------------------------------------------------
// Resampler assertion macros
// Clocked, reset-gated property shorthands for the resampler checker.
// ---------------------------------------------------------------------------
`ifndef CAPTURE_INTERP_DECIMATE_RESAMPLER_TOP_MACROS_SVH
`define CAPTURE_INTERP_DECIMATE_RESAMPLER_TOP_MACROS_SVH

// same-cycle implication
`define CIDR_ASSERT_HOLDS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("resampler check failed");

// next-cycle implication
`define CIDR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("resampler check failed");

`endif

>>> rtl/core/cidr_pkg.sv
// ---------------------------------------------------------------------------
// Resampler package
// Widths, register codes, fixed-point constants and inter-module structs.
// ---------------------------------------------------------------------------
package cidr_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int OUT_ADDR_W = 16;
   localparam int PHASE_W    = 17;
   localparam int FRAC_W     = 16;
   localparam int FACTOR_W   = 6;
   localparam int SUM_W      = 40;
   localparam int PROD_W     = 34;
   localparam int MUL_W      = PHASE_W + 1 + SAMPLE_W + 1;
   localparam int ROUND_SHIFT = FRAC_W - 1;
   localparam int QUOT_W     = 28;
   localparam int DIV_BITS   = 4;
   localparam int DIV_CYCLES = QUOT_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 3;
   localparam int REG_SEL_BIT = 2;
   localparam int JOB_DEPTH  = 2;
   localparam int RES_DEPTH  = 2;

   localparam logic [PHASE_W-1:0]  ONE_Q16      = 17'h10000;
   localparam logic [PHASE_W-1:0]  STEP_MIN     = 17'h08000;
   localparam logic [PHASE_W-1:0]  STEP_RESET   = ONE_Q16;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 6'd1;
   localparam logic [FACTOR_W-1:0] MAX_DIVIDER  = 6'd48;
   localparam logic [SAMPLE_W-1:0] SAT_POS      = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAT_NEG      = 16'h8000;

   typedef enum logic {
      REG_PHASE_STEP = 1'b0,
      REG_DECIMATION = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [PHASE_W-1:0]  phase_step;
      logic [FACTOR_W-1:0] decimation_factor;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] prev_sample;
      logic signed [SAMPLE_W:0]   sample_diff;
      logic                       restart;
   } job_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic [OUT_ADDR_W-1:0]      write_address;
      logic                       run_last;
   } result_type;

   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] sum;
      logic [FACTOR_W-1:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [SAMPLE_W-1:0] avg;
   } div_rsp_type;

   function automatic logic [PHASE_W-1:0] clamp_step(input logic [PHASE_W-1:0] step);
      logic [PHASE_W-1:0] r;
      r = step;
      if (step < STEP_MIN) r = STEP_MIN;
      else if (step > ONE_Q16) r = ONE_Q16;
      return r;
   endfunction

   function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] factor);
      logic [FACTOR_W-1:0] r;
      r = factor;
      if (factor == '0) r = FACTOR_RESET;
      else if (factor > MAX_DIVIDER) r = MAX_DIVIDER;
      return r;
   endfunction

endpackage

>>> rtl/core/capture_interp_decimate_resampler_top.sv
// ---------------------------------------------------------------------------
// Linear-interpolation resampler with boxcar decimation
// Samples enter on a push/full queue port; each samples one or two
// interpolation points at a Q1.16 phase, and every decimation_factor-th
// point yields the rounded, saturated average with its ring-buffer slot.
// Results leave on an empty/pop queue port, oldest first; run_last marks
// the last result an input sample causes. Registers sit on an APB-style
// port: phase_step at 0x0, decimation_factor at 0x4; write only when idle.
// A sample with restart set clears phase, sum, count and sample history.
// Each result goes through the averaging divider: four quotient bits per
// cycle over 28 bits, with sign, rounding and saturation steps.
// Two-entry queues sit before and after the back end, so samples keep
// being taken while a result waits; when the receiver stalls, the result
// queue fills, the back end holds and full rises once the job queue fills.
// Reset restores register defaults and empties both queues, with no
// clearing pass.
// ---------------------------------------------------------------------------
module capture_interp_decimate_resampler_top
   import cidr_pkg::*;
#(
   parameter int RING_DEPTH = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic signed [SAMPLE_W-1:0]   req_in_sample,
   input  logic                         req_restart,
   input  logic                         req_block_last,
   output logic                         empty,
   input  logic                         pop,
   output logic signed [SAMPLE_W-1:0]   rsp_out_sample,
   output logic [OUT_ADDR_W-1:0]        rsp_write_address,
   output logic                         rsp_run_last,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ADDR_W-1:0]            paddr,
   input  logic [DATA_W-1:0]            pwdata,
   output logic [DATA_W-1:0]            prdata,
   output logic                         pready
);

   logic [PHASE_W-1:0]  step_ff, step_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   cfg_type             cfg;
   reg_index_type       reg_sel;

   logic                job_push;
   job_type             job_wr;
   logic                job_full;
   logic                job_empty;
   logic                job_pop;
   job_type             job_rd;
   logic                res_push;
   logic                res_full;
   result_type          res_wr;
   result_type          res_rd;
   div_req_type         div_req;
   div_rsp_type         div_rsp;
   logic                frame_unused;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[REG_SEL_BIT]);
   assign cfg.phase_step        = step_ff;
   assign cfg.decimation_factor = factor_ff;
   assign full = job_full;
   assign frame_unused = req_block_last;

   always_comb begin
      step_in   = step_ff;
      factor_in = factor_ff;
      if (psel && penable && pwrite && pready) begin
         unique case (reg_sel)
            REG_PHASE_STEP: step_in   = pwdata[PHASE_W-1:0];
            REG_DECIMATION: factor_in = pwdata[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_PHASE_STEP: prdata = DATA_W'(step_ff);
         REG_DECIMATION: prdata = DATA_W'(factor_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_RESET;
         factor_ff <= FACTOR_RESET;
      end else begin
         step_ff   <= step_in;
         factor_ff <= factor_in;
      end
   end

   cidr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .req_in_sample (req_in_sample),
      .req_restart   (req_restart),
      .job_full      (job_full),
      .job_push      (job_push),
      .job_data      (job_wr)
   );

   cidr_fifo #(
      .WIDTH ($bits(job_type)),
      .DEPTH (JOB_DEPTH)
   ) u_job_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (job_wr),
      .full    (job_full),
      .rd_en   (job_pop),
      .rd_data (job_rd),
      .empty   (job_empty)
   );

   cidr_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_empty (job_empty),
      .job       (job_rd),
      .job_pop   (job_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res_wr),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   cidr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   cidr_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RES_DEPTH)
   ) u_res_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res_wr),
      .full    (res_full),
      .rd_en   (pop),
      .rd_data (res_rd),
      .empty   (empty)
   );

   assign rsp_out_sample    = res_rd.out_sample;
   assign rsp_write_address = res_rd.write_address;
   assign rsp_run_last      = res_rd.run_last;

endmodule

>>> rtl/core/cidr_fifo.sv
// ---------------------------------------------------------------------------
// Resampler queue
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module cidr_fifo
   import cidr_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wr_fire;
   logic             rd_fire;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign wr_fire = wr_en && !full;
   assign rd_fire = rd_en && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(wr_fire) - CNT_W'(rd_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/core/cidr_front.sv
// ---------------------------------------------------------------------------
// Resampler front end
// Accept samples, pair each with the one before it and queue the job.
// ---------------------------------------------------------------------------
module cidr_front
   import cidr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic signed [SAMPLE_W-1:0] req_in_sample,
   input  logic                       req_restart,
   input  logic                       job_full,
   output logic                       job_push,
   output job_type                    job_data
);

   logic signed [SAMPLE_W-1:0] newest_ff, newest_in;
   logic signed [SAMPLE_W-1:0] prev;

   assign job_push = push && !job_full;
   assign prev     = req_restart ? '0 : newest_ff;
   assign newest_in = job_push ? req_in_sample : newest_ff;

   assign job_data.prev_sample = prev;
   assign job_data.sample_diff = {req_in_sample[SAMPLE_W-1], req_in_sample}
                               - {prev[SAMPLE_W-1], prev};
   assign job_data.restart     = req_restart;

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff <= '0;
      end else begin
         newest_ff <= newest_in;
      end
   end

endmodule

>>> rtl/core/cidr_div.sv
// ---------------------------------------------------------------------------
// Resampler averaging divider
// Round-half-away average of a Q.16 sum, four quotient bits per cycle.
// ---------------------------------------------------------------------------
module cidr_div
   import cidr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   typedef enum logic [2:0] {
      D_IDLE,
      D_ABS,
      D_RND,
      D_RUN,
      D_SAT
   } state_type;

   state_type            state_ff, state_in;
   logic                 neg_ff, neg_in;
   logic [SUM_W-1:0]     mag_ff, mag_in;
   logic [FACTOR_W-1:0]  divisor_ff, divisor_in;
   logic [QUOT_W-1:0]    work_ff, work_in;
   logic [FACTOR_W-1:0]  rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [SAMPLE_W-1:0]  avg_ff, avg_in;
   logic [SUM_W-1:0]     rounded;
   logic [QUOT_W-1:0]    neg_quot;
   logic [FACTOR_W:0]    trial;

   assign div_rsp.done = done_ff;
   assign div_rsp.avg  = avg_ff;

   always_comb begin
      state_in   = state_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      divisor_in = divisor_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      avg_in     = avg_ff;
      done_in    = 1'b0;
      trial      = '0;
      rounded    = mag_ff + (SUM_W'(divisor_ff) << ROUND_SHIFT);
      neg_quot   = '0 - work_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (div_req.start) begin
               mag_in     = div_req.sum;
               neg_in     = div_req.sum[SUM_W-1];
               divisor_in = div_req.divisor;
               state_in   = D_ABS;
            end
         end
         D_ABS: begin
            if (neg_ff) mag_in = '0 - mag_ff;
            state_in = D_RND;
         end
         D_RND: begin
            work_in  = QUOT_W'(rounded[SUM_W-1:FRAC_W]);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = D_RUN;
         end
         D_RUN: begin
            for (int i = 0; i < DIV_BITS; i++) begin
               trial   = {rem_in, work_in[QUOT_W-1]};
               work_in = {work_in[QUOT_W-2:0], 1'b0};
               if (trial >= {1'b0, divisor_ff}) begin
                  trial      = trial - {1'b0, divisor_ff};
                  work_in[0] = 1'b1;
               end
               rem_in = trial[FACTOR_W-1:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) state_in = D_SAT;
         end
         D_SAT: begin
            if (neg_ff) begin
               avg_in = (work_ff > QUOT_W'(SAT_NEG)) ? SAT_NEG : neg_quot[SAMPLE_W-1:0];
            end else begin
               avg_in = (work_ff > QUOT_W'(SAT_POS)) ? SAT_POS : work_ff[SAMPLE_W-1:0];
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         done_ff    <= done_in;
         neg_ff     <= neg_in;
         mag_ff     <= mag_in;
         divisor_ff <= divisor_in;
         work_ff    <= work_in;
         rem_ff     <= rem_in;
         cnt_ff     <= cnt_in;
         avg_ff     <= avg_in;
      end
   end

endmodule

>>> rtl/core/cidr_back.sv
// ---------------------------------------------------------------------------
// Resampler back end
// Interpolate points, accumulate, hand sums to the divider, emit results.
// ---------------------------------------------------------------------------
module cidr_back
   import cidr_pkg::*;
#(
   parameter int RING_DEPTH = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        job_empty,
   input  job_type     job,
   output logic        job_pop,
   input  logic        res_full,
   output logic        res_push,
   output result_type  res,
   output div_req_type div_req,
   input  div_rsp_type div_rsp
);

   localparam int RING_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_ACC,
      B_DIV,
      B_OUT
   } state_type;

   state_type                  state_ff, state_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [FACTOR_W-1:0]        count_ff, count_in;
   logic [RING_W-1:0]          ring_ff, ring_in;
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic signed [SAMPLE_W:0]   diff_ff, diff_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       last_ff, last_in;
   logic                       run_last_ff, run_last_in;
   logic signed [SAMPLE_W-1:0] avg_ff, avg_in;

   logic [PHASE_W-1:0]         step;
   logic [FACTOR_W-1:0]        factor;
   logic signed [MUL_W-1:0]    mul;
   logic [SUM_W-1:0]           base;
   logic signed [SUM_W-1:0]    acc;
   logic [FACTOR_W-1:0]        count_nxt;
   logic [PHASE_W-1:0]         step_sum;
   logic                       emit;
   logic                       last_point;

   assign step   = clamp_step(cfg.phase_step);
   assign factor = clamp_factor(cfg.decimation_factor);

   assign mul        = $signed({1'b0, phase_ff}) * diff_ff;
   assign base       = {{(SUM_W-SAMPLE_W-FRAC_W){prev_ff[SAMPLE_W-1]}}, prev_ff, {FRAC_W{1'b0}}};
   assign acc        = sum_ff + {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign count_nxt  = count_ff + 1'b1;
   assign emit       = (count_nxt >= factor);
   assign step_sum   = phase_ff + step;
   assign last_point = step_sum[PHASE_W-1];

   assign job_pop  = (state_ff == B_IDLE) && !job_empty;
   assign res_push = (state_ff == B_OUT) && !res_full;

   assign res.out_sample    = avg_ff;
   assign res.write_address = OUT_ADDR_W'(ring_ff);
   assign res.run_last      = run_last_ff;

   assign div_req.start   = (state_ff == B_ACC) && emit;
   assign div_req.sum     = acc;
   assign div_req.divisor = factor;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      ring_in     = ring_ff;
      prev_in     = prev_ff;
      diff_in     = diff_ff;
      prod_in     = prod_ff;
      last_in     = last_ff;
      run_last_in = run_last_ff;
      avg_in      = avg_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               prev_in = job.prev_sample;
               diff_in = job.sample_diff;
               if (job.restart) begin
                  phase_in = '0;
                  sum_in   = '0;
                  count_in = '0;
               end
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            prod_in  = mul[PROD_W-1:0];
            sum_in   = sum_ff + base;
            state_in = B_ACC;
         end
         B_ACC: begin
            phase_in = last_point ? {1'b0, step_sum[PHASE_W-2:0]} : step_sum;
            last_in  = last_point;
            if (emit) begin
               sum_in      = '0;
               count_in    = '0;
               run_last_in = last_point || (factor != FACTOR_RESET);
               state_in    = B_DIV;
            end else begin
               sum_in   = acc;
               count_in = count_nxt;
               state_in = last_point ? B_IDLE : B_MUL;
            end
         end
         B_DIV: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.avg;
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (!res_full) begin
               ring_in  = (ring_ff == RING_W'(RING_DEPTH - 1)) ? '0 : ring_ff + 1'b1;
               state_in = last_ff ? B_IDLE : B_MUL;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         phase_ff <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
         ring_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         ring_ff     <= ring_in;
         prev_ff     <= prev_in;
         diff_ff     <= diff_in;
         prod_ff     <= prod_in;
         last_ff     <= last_in;
         run_last_ff <= run_last_in;
         avg_ff      <= avg_in;
      end
   end

endmodule

>>> rtl/core/cidr_checker.sv
// ---------------------------------------------------------------------------
// Resampler port checker
// Port-level properties of the resampler, bound to its top level.
// ---------------------------------------------------------------------------
`include "capture_interp_decimate_resampler_top_macros.svh"

module cidr_checker
   import cidr_pkg::*;
#(
   parameter int RING_DEPTH = 65536
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       empty,
   input logic                       pop,
   input logic signed [SAMPLE_W-1:0] rsp_out_sample,
   input logic [OUT_ADDR_W-1:0]      rsp_write_address,
   input logic                       rsp_run_last,
   input logic                       psel,
   input logic                       penable,
   input logic                       pwrite,
   input logic [ADDR_W-1:0]          paddr,
   input logic [DATA_W-1:0]          pwdata,
   input logic [DATA_W-1:0]          prdata
);

   localparam int RING_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   logic [RING_W-1:0] exp_ff, exp_in;

   // track the slot the next result must carry
   always_comb begin
      exp_in = exp_ff;
      if (pop && !empty) begin
         exp_in = (exp_ff == RING_W'(RING_DEPTH - 1)) ? '0 : exp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= '0;
      end else begin
         exp_ff <= exp_in;
      end
   end

   `CIDR_ASSERT_HOLDS(a_empty_after_reset, $past(reset), empty)

   `CIDR_ASSERT_NEXT(a_step_readback, psel && penable && pwrite && !paddr[REG_SEL_BIT], paddr[REG_SEL_BIT] || (prdata[DATA_W-1:PHASE_W] == '0 && prdata[PHASE_W-1:0] == $past(pwdata[PHASE_W-1:0])))

   `CIDR_ASSERT_NEXT(a_stalled_beat_holds, !empty && !pop, !empty && $stable(rsp_out_sample) && $stable(rsp_write_address) && $stable(rsp_run_last))

   `CIDR_ASSERT_HOLDS(a_slot_sequence, !empty, rsp_write_address == OUT_ADDR_W'(exp_ff))

endmodule

bind capture_interp_decimate_resampler_top cidr_checker #(
   .RING_DEPTH (RING_DEPTH)
) u_checker (.*);

>>> verif/cidr_average_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Resampler result checker
// Watches the sample, result and register ports of the resampler. It keeps
// its own copy of the register settings and the interpolation state, works
// out the averages each accepted sample produces and compares every
// result beat, field by field, with the oldest average still due.
// ---------------------------------------------------------------------------
module cidr_average_checker
   import cidr_pkg::*;
#(
   parameter int RING_SLOTS = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic                       full,
   input  logic signed [SAMPLE_W-1:0] req_in_sample,
   input  logic                       req_restart,
   input  logic                       empty,
   input  logic                       pop,
   input  logic signed [SAMPLE_W-1:0] rsp_out_sample,
   input  logic [OUT_ADDR_W-1:0]      rsp_write_address,
   input  logic                       rsp_run_last,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic                       pready,
   input  logic [ADDR_W-1:0]          paddr,
   input  logic [DATA_W-1:0]          pwdata,
   output int                         mismatches,
   output int                         averages_waiting,
   output int                         averages_checked
);

   localparam int PRINT_CAP = 40;

   logic [PHASE_W-1:0]         step_setting;
   logic [FACTOR_W-1:0]        factor_setting;
   logic signed [SAMPLE_W-1:0] older_sample;
   logic signed [SAMPLE_W-1:0] newer_sample;
   logic [PHASE_W-1:0]         phase;
   logic signed [SUM_W-1:0]    point_sum;
   logic [FACTOR_W-1:0]        point_count;
   int                         ring_slot;
   result_type                 averages_due[$];

   initial begin
      mismatches = 0;
      averages_waiting = 0;
      averages_checked = 0;
   end

   function automatic logic signed [SAMPLE_W-1:0] rounded_average(input longint sum,
                                                                   input int divider);
      longint den;
      longint q;
      den = longint'(divider) * 65536;
      if (sum >= 0) q = (2 * sum + den) / (2 * den);
      else q = -((-2 * sum + den) / (2 * den));
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return SAMPLE_W'(q);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_CAP)
         $display("%0t ns  %s: got %0h, want %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic take_sample(input logic signed [SAMPLE_W-1:0] sample, input logic restart);
      logic [PHASE_W-1:0]  step;
      logic [FACTOR_W-1:0] divider;
      longint              diff;
      longint              point;
      result_type          made [2];
      int                  n;
      step = step_setting;
      if (step < STEP_MIN) step = STEP_MIN;
      else if (step > ONE_Q16) step = ONE_Q16;
      divider = factor_setting;
      if (divider == '0) divider = FACTOR_RESET;
      else if (divider > MAX_DIVIDER) divider = MAX_DIVIDER;
      if (restart) begin
         phase = '0;
         point_sum = '0;
         point_count = '0;
         older_sample = '0;
         newer_sample = '0;
      end
      older_sample = newer_sample;
      newer_sample = sample;
      diff = longint'(newer_sample) - longint'(older_sample);
      n = 0;
      while (phase < ONE_Q16 && n < 2) begin
         point = longint'(older_sample) * 65536 + longint'(phase) * diff;
         point_sum = point_sum + SUM_W'(point);
         point_count = point_count + 1'b1;
         if (point_count >= divider) begin
            made[n].out_sample = rounded_average(longint'(point_sum), int'(divider));
            made[n].write_address = ring_slot[OUT_ADDR_W-1:0];
            made[n].run_last = 1'b0;
            n++;
            ring_slot = (ring_slot + 1 >= RING_SLOTS) ? 0 : ring_slot + 1;
            point_sum = '0;
            point_count = '0;
         end
         phase = phase + step;
      end
      phase = (phase >= ONE_Q16) ? phase - ONE_Q16 : '0;
      if (n > 0) made[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) averages_due.push_back(made[i]);
      averages_waiting = averages_due.size();
   endtask

   task automatic check_beat();
      result_type want;
      if (averages_due.size() == 0) begin
         report_mismatch("result beat with no average due", 32'(rsp_out_sample), '0);
      end else begin
         want = averages_due.pop_front();
         averages_waiting = averages_due.size();
         if (rsp_out_sample !== want.out_sample)
            report_mismatch("out_sample", 32'(rsp_out_sample), 32'(want.out_sample));
         if (rsp_write_address !== want.write_address)
            report_mismatch("write_address", 32'(rsp_write_address), 32'(want.write_address));
         if (rsp_run_last !== want.run_last)
            report_mismatch("run_last", 32'(rsp_run_last), 32'(want.run_last));
         averages_checked++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         step_setting = STEP_RESET;
         factor_setting = FACTOR_RESET;
         older_sample = '0;
         newer_sample = '0;
         phase = '0;
         point_sum = '0;
         point_count = '0;
         ring_slot = 0;
         averages_due.delete();
         averages_waiting = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[REG_SEL_BIT]))
               REG_PHASE_STEP: step_setting = pwdata[PHASE_W-1:0];
               REG_DECIMATION: factor_setting = pwdata[FACTOR_W-1:0];
            endcase
         end
         if (pop && !empty) check_beat();
         if (push && !full) take_sample(req_in_sample, req_restart);
      end
   end

endmodule

>>> verif/capture_interp_decimate_resampler_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Resampler testbench
// Drives samples in bursts with random gaps while the result side pops on
// changing patterns, steps the phase and divider registers through their
// extremes and out-of-range values between runs, and lets the checker
// compare every averaged beat. The ring depth is cut down so that the
// write address can wrap.
// ---------------------------------------------------------------------------
module capture_interp_decimate_resampler_top_tb;
   import cidr_pkg::*;

   localparam int RING_SLOTS    = 1021;
   localparam int RANDOM_ROUNDS = 12;
   localparam int ROUND_ITEMS   = 138;
   localparam int SETTLE_CYCLES = 64;
   localparam int QUIET_LIMIT   = 2000;

   typedef enum logic [1:0] {
      PACE_FLOW,
      PACE_COIN,
      PACE_MASK,
      PACE_HOLD
   } pace_mode_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       push = 1'b0;
   logic                       full;
   logic signed [SAMPLE_W-1:0] req_in_sample = '0;
   logic                       req_restart = 1'b0;
   logic                       req_block_last = 1'b0;
   logic                       empty;
   logic                       pop = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_out_sample;
   logic [OUT_ADDR_W-1:0]      rsp_write_address;
   logic                       rsp_run_last;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [ADDR_W-1:0]          paddr = '0;
   logic [DATA_W-1:0]          pwdata = '0;
   logic [DATA_W-1:0]          prdata;
   logic                       pready;

   int mismatches;
   int averages_waiting;
   int averages_checked;
   int samples_sent = 0;
   int restarts_sent = 0;
   int settings_used = 1;

   pace_mode_type pace_mode = PACE_FLOW;
   int            pace_left = 0;
   logic [7:0]    pace_mask = 8'hFF;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   capture_interp_decimate_resampler_top #(
      .RING_DEPTH(RING_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_in_sample(req_in_sample),
      .req_restart(req_restart),
      .req_block_last(req_block_last),
      .empty(empty),
      .pop(pop),
      .rsp_out_sample(rsp_out_sample),
      .rsp_write_address(rsp_write_address),
      .rsp_run_last(rsp_run_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   cidr_average_checker #(
      .RING_SLOTS(RING_SLOTS)
   ) result_check (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_in_sample(req_in_sample),
      .req_restart(req_restart),
      .empty(empty),
      .pop(pop),
      .rsp_out_sample(rsp_out_sample),
      .rsp_write_address(rsp_write_address),
      .rsp_run_last(rsp_run_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .pready(pready),
      .paddr(paddr),
      .pwdata(pwdata),
      .mismatches(mismatches),
      .averages_waiting(averages_waiting),
      .averages_checked(averages_checked)
   );

   // vary the pop pattern in stretches: free flow, coin toss, rotating mask, hold
   always @(negedge clock) begin : rsp_pacing
      logic take;
      if (pace_left == 0) begin
         case ($urandom_range(0, 7))
            0, 1, 2: pace_mode = PACE_FLOW;
            3, 4:    pace_mode = PACE_COIN;
            5, 6:    pace_mode = PACE_MASK;
            default: pace_mode = PACE_HOLD;
         endcase
         pace_left = $urandom_range(4, 40);
         pace_mask = 8'($urandom) | 8'h01;
      end
      case (pace_mode)
         PACE_FLOW: take = 1'b1;
         PACE_COIN: take = $urandom_range(0, 1);
         PACE_MASK: begin
            take = pace_mask[0];
            pace_mask = {pace_mask[0], pace_mask[7:1]};
         end
         default: take = 1'b0;
      endcase
      pace_left--;
      pop <= take;
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty) || (psel && penable)) quiet = 0;
         else quiet++;
      end
      $display("Timed out after %0d cycles with no beat moving.", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic restart,
                              input logic last);
      req_in_sample <= value;
      req_restart <= restart;
      req_block_last <= last;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      samples_sent++;
      if (restart) restarts_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      push <= 1'b0;
      while (averages_waiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type index, input logic [DATA_W-1:0] value);
      paddr <= ADDR_W'(index) << REG_SEL_BIT;
      pwdata <= value;
      pwrite <= 1'b1;
      psel <= 1'b1;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return SAT_POS;
         1:       return SAT_NEG;
         2, 3:    return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic run_items(input int count);
      int left;
      int gap;
      left = $urandom_range(1, 24);
      for (int i = 0; i < count; i++) begin
         if (left == 0) begin
            case ($urandom_range(0, 7))
               0, 1:    gap = 0;
               7:       gap = $urandom_range(16, 40);
               default: gap = $urandom_range(1, 8);
            endcase
            if (gap != 0) begin
               push <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            left = $urandom_range(1, 24);
         end
         send_sample(pick_sample(), $urandom_range(0, 47) == 0, $urandom_range(0, 15) == 0);
         left--;
      end
   endtask

   initial begin
      logic [PHASE_W-1:0]  step;
      logic [FACTOR_W-1:0] factor;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: unit step, one point per average
      send_sample(SAT_POS, 1'b0, 1'b0);
      send_sample(SAT_NEG, 1'b0, 1'b1);
      send_sample('0, 1'b1, 1'b0);
      send_sample(-16'sd1, 1'b0, 1'b0);
      send_sample(16'sd1, 1'b0, 1'b1);
      settle();

      // step below range and zero divider
      csr_write(REG_PHASE_STEP, '0);
      csr_write(REG_DECIMATION, '0);
      settings_used++;
      send_sample(SAT_POS, 1'b0, 1'b0);
      send_sample(SAT_NEG, 1'b0, 1'b1);
      send_sample(16'sd7, 1'b1, 1'b0);
      send_sample(-16'sd8, 1'b0, 1'b0);
      settle();

      // step above range and divider past its ceiling: points pile up
      csr_write(REG_PHASE_STEP, 32'h0001_FFFF);
      csr_write(REG_DECIMATION, 32'h0000_003F);
      settings_used++;
      for (int i = 0; i < 6; i++) send_sample(SAT_POS, i == 0, 1'b0);
      settle();

      // lower the divider with points held, forcing a saturated average
      csr_write(REG_DECIMATION, 32'd2);
      settings_used++;
      send_sample(SAT_POS, 1'b0, 1'b0);
      send_sample(SAT_POS, 1'b0, 1'b1);
      send_sample(SAT_NEG, 1'b0, 1'b0);
      send_sample(SAT_NEG, 1'b0, 1'b0);
      send_sample(SAT_POS, 1'b0, 1'b1);
      settle();

      for (int r = 0; r < RANDOM_ROUNDS; r++) begin
         case (r)
            0: begin step = STEP_MIN; factor = FACTOR_RESET; end
            1: begin step = ONE_Q16; factor = MAX_DIVIDER; end
            2: begin step = STEP_MIN; factor = MAX_DIVIDER; end
            3: begin step = ONE_Q16; factor = FACTOR_RESET; end
            default: begin
               case ($urandom_range(0, 5))
                  0:       step = PHASE_W'($urandom_range(0, 32767));
                  1:       step = PHASE_W'($urandom_range(65537, 131071));
                  default: step = PHASE_W'($urandom_range(32768, 65536));
               endcase
               case ($urandom_range(0, 5))
                  0:       factor = '0;
                  1:       factor = FACTOR_W'($urandom_range(49, 63));
                  default: factor = FACTOR_W'($urandom_range(2, 47));
               endcase
            end
         endcase
         csr_write(REG_PHASE_STEP, (DATA_W'($urandom) << PHASE_W) | DATA_W'(step));
         csr_write(REG_DECIMATION, (DATA_W'($urandom) << FACTOR_W) | DATA_W'(factor));
         settings_used++;
         run_items(ROUND_ITEMS);
         settle();
      end

      $display("Sent %0d samples (%0d with restart) under %0d register settings, ring of %0d.",
               samples_sent, restarts_sent, settings_used, RING_SLOTS);
      $display("Checked %0d averaged beats: %0d mismatches, %0d still due.",
               averages_checked, mismatches, averages_waiting);
      if (mismatches == 0 && averages_waiting == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/cidr_pkg.sv
rtl/core/cidr_fifo.sv
rtl/core/cidr_front.sv
rtl/core/cidr_div.sv
rtl/core/cidr_back.sv
rtl/core/capture_interp_decimate_resampler_top.sv
rtl/core/cidr_checker.sv
verif/cidr_average_checker.sv
verif/capture_interp_decimate_resampler_top_tb.sv
